// ===== rtl/fpep_pkg.sv =====
package fpep_pkg;

    // Geometry of the device and the request limits.
    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;
    localparam int MAX_LENGTH   = 4096;
    localparam int RESULT_LIMIT = 17;

    // Field widths fixed by the interface.
    localparam int ADDR_W   = 24;
    localparam int LEN_W    = 13;
    localparam int CMD_W    = 8;
    localparam int COUNT_W  = 9;
    localparam int OFFSET_W = 12;

    // Derived internal widths.
    localparam int PAGE_W   = $clog2(PAGE_BYTES);
    localparam int SECTOR_W = $clog2(SECTOR_BYTES);
    localparam int CHUNK_W  = PAGE_W + 1;
    localparam int SPAN_W   = $clog2(SECTOR_BYTES + MAX_LENGTH) + 1;
    localparam int NUM_W    = $clog2(RESULT_LIMIT + 1);

    localparam logic [CMD_W-1:0] CMD_PAGE_PROGRAM = 8'h02;
    localparam logic [CMD_W-1:0] CMD_SECTOR_ERASE = 8'h20;

    typedef enum logic {
        MODE_PROGRAM = 1'b0,
        MODE_ERASE   = 1'b1
    } t_mode;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] start_address;
        logic [LEN_W-1:0]  length;
    } t_request;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [ADDR_W-1:0]   op_address;
        logic [COUNT_W-1:0]  byte_count;
        logic [OFFSET_W-1:0] buffer_offset;
        logic                last;
    } t_result;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic len_zero;
        logic fin;
    } t_dp_status;

endpackage

// ===== rtl/fpep_ctrl.sv =====
module fpep_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  fpep_pkg::t_dp_status  i_status,
    output fpep_pkg::t_dp_cmd     o_cmd,
    output logic                  o_busy,
    output logic                  o_valid
);

    fpep_pkg::t_state r_state;
    fpep_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpep_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fpep_pkg::ST_IDLE: begin
                if (i_start && !i_status.len_zero) begin
                    n_state = fpep_pkg::ST_RUN;
                end
            end
            fpep_pkg::ST_RUN: begin
                if (i_status.fin) begin
                    n_state = fpep_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fpep_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        o_busy     = 1'b0;
        o_valid    = 1'b0;
        case (r_state)
            fpep_pkg::ST_IDLE: begin
                o_cmd.load = i_start && !i_status.len_zero;
            end
            fpep_pkg::ST_RUN: begin
                o_cmd.step = 1'b1;
                o_busy     = 1'b1;
                o_valid    = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/fpep_dp.sv =====
module fpep_dp (
    input  logic                  i_clk,
    input  fpep_pkg::t_request    i_req,
    input  fpep_pkg::t_dp_cmd     i_cmd,
    output fpep_pkg::t_dp_status  o_status,
    output fpep_pkg::t_result     o_res
);

    localparam int ADDR_W   = fpep_pkg::ADDR_W;
    localparam int SPAN_W   = fpep_pkg::SPAN_W;
    localparam int CHUNK_W  = fpep_pkg::CHUNK_W;
    localparam int PAGE_W   = fpep_pkg::PAGE_W;
    localparam int SECTOR_W = fpep_pkg::SECTOR_W;
    localparam int NUM_W    = fpep_pkg::NUM_W;
    localparam int OFF_W    = fpep_pkg::LEN_W;

    localparam logic [CHUNK_W-1:0] PAGE_SIZE   = CHUNK_W'(fpep_pkg::PAGE_BYTES);
    localparam logic [SPAN_W-1:0]  SECTOR_SPAN = SPAN_W'(fpep_pkg::SECTOR_BYTES);
    localparam logic [ADDR_W-1:0]  SECTOR_STEP = ADDR_W'(fpep_pkg::SECTOR_BYTES);
    localparam logic [fpep_pkg::LEN_W-1:0] MAX_LEN =
        fpep_pkg::LEN_W'(fpep_pkg::MAX_LENGTH);
    localparam logic [NUM_W-1:0] LAST_NUM = NUM_W'(fpep_pkg::RESULT_LIMIT - 1);

    logic                         r_mode;
    logic [ADDR_W-1:0]            r_addr;
    logic [SPAN_W-1:0]            r_rem;
    logic [OFF_W-1:0]             r_offset;
    logic [NUM_W-1:0]             r_num;

    logic [fpep_pkg::LEN_W-1:0]   len_sat;
    logic [CHUNK_W-1:0]           page_room;
    logic [CHUNK_W-1:0]           chunk;
    logic                         rem_fits_page;
    logic                         fin;
    logic [ADDR_W-1:0]            sector_base;

    assign len_sat = (i_req.length > MAX_LEN) ? MAX_LEN : i_req.length;

    assign page_room     = PAGE_SIZE - {1'b0, r_addr[PAGE_W-1:0]};
    assign rem_fits_page = r_rem <= SPAN_W'(page_room);
    assign chunk         = rem_fits_page ? r_rem[CHUNK_W-1:0] : page_room;

    // Erase steps go to the next sector base; the first carries the raw address.
    assign sector_base = {r_addr[ADDR_W-1:SECTOR_W], {SECTOR_W{1'b0}}};

    always_comb begin
        if (r_mode == fpep_pkg::MODE_PROGRAM) begin
            fin = rem_fits_page;
        end else begin
            fin = r_rem <= SECTOR_SPAN;
        end
        if (r_num == LAST_NUM) begin
            fin = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_req.mode;
            r_addr   <= i_req.start_address;
            r_offset <= '0;
            r_num    <= '0;
            if (i_req.mode == fpep_pkg::MODE_PROGRAM) begin
                r_rem <= SPAN_W'(len_sat);
            end else begin
                r_rem <= SPAN_W'(i_req.start_address[SECTOR_W-1:0]) + SPAN_W'(len_sat);
            end
        end else if (i_cmd.step) begin
            r_num <= r_num + 1'b1;
            if (r_mode == fpep_pkg::MODE_PROGRAM) begin
                r_addr   <= r_addr + ADDR_W'(chunk);
                r_offset <= r_offset + OFF_W'(chunk);
                r_rem    <= r_rem - SPAN_W'(chunk);
            end else begin
                r_addr <= sector_base + SECTOR_STEP;
                r_rem  <= r_rem - SECTOR_SPAN;
            end
        end
    end

    assign o_status.len_zero = (len_sat == '0);
    assign o_status.fin      = fin;

    always_comb begin
        o_res.op_address = r_addr;
        o_res.last       = fin;
        if (r_mode == fpep_pkg::MODE_PROGRAM) begin
            o_res.command       = fpep_pkg::CMD_PAGE_PROGRAM;
            o_res.byte_count    = fpep_pkg::COUNT_W'(chunk);
            o_res.buffer_offset = r_offset[fpep_pkg::OFFSET_W-1:0];
        end else begin
            o_res.command       = fpep_pkg::CMD_SECTOR_ERASE;
            o_res.byte_count    = '0;
            o_res.buffer_offset = '0;
        end
    end

endmodule

// ===== rtl/flash_program_erase_planner_core.sv =====
// The first operation appears on o_res in the cycle after start is taken.
// One operation per cycle; busy stays high while a request's operations are issued
// (up to 17 operations here: 16 page chunks plus one, or 2 sectors).
// A zero-length request is taken without busy and yields no operation.
// Reset is synchronous and active low; it returns the controller to idle.
// The receiver cannot stall: each operation is valid for exactly one cycle.
module flash_program_erase_planner_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  fpep_pkg::t_request i_req,
    output logic               o_valid,
    output fpep_pkg::t_result  o_res
);

    fpep_pkg::t_dp_cmd    dp_cmd;
    fpep_pkg::t_dp_status dp_status;

    fpep_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    fpep_dp u_dp (
        .i_clk    (i_clk),
        .i_req    (i_req),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_res    (o_res)
    );

endmodule

// ===== tb/fpep_op_checker.sv =====
`timescale 1ns / 1ps

module fpep_op_checker
    import fpep_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_request i_req,
    input  logic     i_valid,
    input  t_result  i_res,
    output int       o_mismatch_count,
    output int       o_ops_pending
);

    t_result planned_ops[$];

    // Work out the flash operations that one request should produce, in the order they are issued.
    task automatic plan_flash_ops(input t_request req);
        logic [31:0]       len;
        logic [31:0]       remaining;
        logic [31:0]       offset;
        logic [31:0]       chunk;
        logic [31:0]       in_sector;
        logic [31:0]       base;
        logic [31:0]       sectors;
        logic [31:0]       sector_addr;
        logic [31:0]       addr;
        int                n;
        t_result           op;
        len = 32'(req.length);
        if (len > 32'(MAX_LENGTH)) begin
            len = 32'(MAX_LENGTH);
        end
        if (len != 32'd0) begin
            if (req.mode == MODE_PROGRAM) begin
                addr      = 32'(req.start_address);
                remaining = len;
                offset    = '0;
                n         = 0;
                while (remaining != 32'd0 && n < RESULT_LIMIT) begin
                    chunk = 32'(PAGE_BYTES) - (addr % 32'(PAGE_BYTES));
                    if (chunk > remaining) begin
                        chunk = remaining;
                    end
                    op.command       = CMD_PAGE_PROGRAM;
                    op.op_address    = addr[ADDR_W-1:0];
                    op.byte_count    = chunk[COUNT_W-1:0];
                    op.buffer_offset = offset[OFFSET_W-1:0];
                    op.last          = (chunk == remaining) || (n == RESULT_LIMIT - 1);
                    planned_ops.push_back(op);
                    n++;
                    addr      = (addr + chunk) & 32'h00FF_FFFF;
                    offset    = offset + chunk;
                    remaining = remaining - chunk;
                end
            end else begin
                in_sector = 32'(req.start_address) % 32'(SECTOR_BYTES);
                base      = 32'(req.start_address) - in_sector;
                sectors   = (in_sector + len + 32'(SECTOR_BYTES) - 32'd1) / 32'(SECTOR_BYTES);
                for (n = 0; 32'(n) < sectors && n < RESULT_LIMIT; n++) begin
                    // The first erase keeps the caller's address; later ones use sector bases.
                    sector_addr      = (n == 0) ? 32'(req.start_address)
                                                : base + 32'(n) * 32'(SECTOR_BYTES);
                    op.command       = CMD_SECTOR_ERASE;
                    op.op_address    = sector_addr[ADDR_W-1:0];
                    op.byte_count    = '0;
                    op.buffer_offset = '0;
                    op.last          = (32'(n) + 32'd1 == sectors) || (n == RESULT_LIMIT - 1);
                    planned_ops.push_back(op);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (i_rst_n) begin
            // Results are checked before a new request is queued behind them.
            if (i_valid) begin
                if (planned_ops.size() == 0) begin
                    if (o_mismatch_count < 10) begin
                        $display({"[%0t] unexpected operation: expected none, ",
                                  "got cmd=%h addr=%h cnt=%0d off=%0d last=%b"},
                                 $realtime, i_res.command, i_res.op_address,
                                 i_res.byte_count, i_res.buffer_offset, i_res.last);
                    end
                    o_mismatch_count++;
                end else begin
                    want = planned_ops.pop_front();
                    if (i_res.command !== want.command || i_res.op_address !== want.op_address
                        || i_res.byte_count !== want.byte_count
                        || i_res.buffer_offset !== want.buffer_offset
                        || i_res.last !== want.last) begin
                        if (o_mismatch_count < 10) begin
                            $display({"[%0t] operation mismatch: expected ",
                                      "cmd=%h addr=%h cnt=%0d off=%0d last=%b"},
                                     $realtime, want.command, want.op_address,
                                     want.byte_count, want.buffer_offset, want.last);
                            $display("    got cmd=%h addr=%h cnt=%0d off=%0d last=%b",
                                     i_res.command, i_res.op_address, i_res.byte_count,
                                     i_res.buffer_offset, i_res.last);
                        end
                        o_mismatch_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                plan_flash_ops(i_req);
            end
        end
        o_ops_pending = planned_ops.size();
    end

endmodule

// ===== tb/tb_flash_program_erase_planner_core.sv =====
`timescale 1ns / 1ps

module tb_flash_program_erase_planner_core;
    import fpep_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    t_request req;
    logic     op_valid;
    t_result  op;
    int       mismatch_count;
    int       ops_pending;

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    flash_program_erase_planner_core DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (req),
        .o_valid (op_valid),
        .o_res   (op)
    );

    fpep_op_checker checker_inst (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_req            (req),
        .i_valid          (op_valid),
        .i_res            (op),
        .o_mismatch_count (mismatch_count),
        .o_ops_pending    (ops_pending)
    );

    function automatic t_request make_req(input t_mode m, input logic [ADDR_W-1:0] a,
                                          input logic [LEN_W-1:0] n);
        t_request r;
        r.mode          = m;
        r.start_address = a;
        r.length        = n;
        return r;
    endfunction

    function automatic t_request random_request();
        t_request    r;
        logic [31:0] rnd;
        rnd    = $urandom;
        r.mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            4:       r.start_address = {rnd[23:8], 8'h00};
            5:       r.start_address = {rnd[23:8], 4'hF, rnd[3:0]};
            6:       r.start_address = {rnd[23:12], 4'hF, rnd[7:0]};
            7:       r.start_address = {rnd[23:12], 12'h000};
            8:       r.start_address = 24'(32'h00FF_FFFF - $urandom_range(0, 4200));
            9:       r.start_address = {12'h000, rnd[11:0]};
            default: r.start_address = rnd[23:0];
        endcase
        rnd = $urandom;
        case ($urandom_range(0, 9))
            0:       r.length = rnd[12:0];
            1, 2:    r.length = 13'($urandom_range(1, 16));
            3, 4:    r.length = 13'($urandom_range(1, MAX_LENGTH));
            5:       r.length = 13'($urandom_range(MAX_LENGTH - 6, MAX_LENGTH));
            6: begin
                case ($urandom_range(0, 8))
                    0:       r.length = 13'd0;
                    1:       r.length = 13'd1;
                    2:       r.length = 13'd255;
                    3:       r.length = 13'd256;
                    4:       r.length = 13'd257;
                    5:       r.length = 13'd4095;
                    6:       r.length = 13'd4096;
                    7:       r.length = 13'd4097;
                    default: r.length = 13'd8191;
                endcase
            end
            7:       r.length = 13'($urandom_range(MAX_LENGTH + 1, 8191));
            default: r.length = 13'($urandom_range(1, 600));
        endcase
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic issue_request(input t_request r, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do begin
            @(posedge clk);
        end while (busy);
        @(negedge clk);
    endtask

    task automatic drain_ops();
        start <= 1'b0;
        @(negedge clk);
        while (ops_pending != 0) begin
            @(negedge clk);
        end
    endtask

    initial begin
        #2000000;
        $display("** flash_program_erase_planner_core: FAILED **");
        $finish;
    end

    initial begin : stimulus
        t_request directed[$];
        bit       no_idle;
        int       gap;
        int       guard;
        start = 1'b0;
        req   = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed.push_back(make_req(MODE_PROGRAM, 24'h000000, 13'd0));
        directed.push_back(make_req(MODE_ERASE, 24'h123456, 13'd0));
        directed.push_back(make_req(MODE_PROGRAM, 24'h000000, 13'd1));
        directed.push_back(make_req(MODE_PROGRAM, 24'h000100, 13'd256));
        directed.push_back(make_req(MODE_PROGRAM, 24'h0001FF, 13'd2));
        directed.push_back(make_req(MODE_PROGRAM, 24'h000000, 13'd4096));
        directed.push_back(make_req(MODE_PROGRAM, 24'h0000FF, 13'd4096));
        directed.push_back(make_req(MODE_PROGRAM, 24'h000080, 13'd8191));
        directed.push_back(make_req(MODE_PROGRAM, 24'h555555, 13'd4097));
        directed.push_back(make_req(MODE_PROGRAM, 24'hFFFFF0, 13'd64));
        directed.push_back(make_req(MODE_PROGRAM, 24'hFFFF00, 13'd4096));
        directed.push_back(make_req(MODE_PROGRAM, 24'hFFFFFF, 13'd8191));
        directed.push_back(make_req(MODE_ERASE, 24'h000000, 13'd1));
        directed.push_back(make_req(MODE_ERASE, 24'h000FFF, 13'd1));
        directed.push_back(make_req(MODE_ERASE, 24'h000FFF, 13'd2));
        directed.push_back(make_req(MODE_ERASE, 24'h001000, 13'd4096));
        directed.push_back(make_req(MODE_ERASE, 24'h001001, 13'd4096));
        directed.push_back(make_req(MODE_ERASE, 24'hFFFFFF, 13'd8191));
        directed.push_back(make_req(MODE_ERASE, 24'hABCDEF, 13'd4097));
        directed.push_back(make_req(MODE_ERASE, 24'hFFF000, 13'd4096));
        foreach (directed[i]) begin
            issue_request(directed[i], $urandom_range(0, 9));
        end
        drain_ops();

        no_idle = 1'b0;
        for (int i = 0; i < 290; i++) begin
            if (i % 25 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (i == 150 || $urandom_range(0, 40) == 0) begin
                drain_ops();
            end
            gap = no_idle ? 0 : $urandom_range(0, 9);
            issue_request(random_request(), gap);
        end

        start <= 1'b0;
        guard = 0;
        while (ops_pending != 0 && guard < 400) begin
            @(negedge clk);
            guard++;
        end
        repeat (4) @(negedge clk);
        if (mismatch_count == 0 && ops_pending == 0) begin
            $display("** flash_program_erase_planner_core: PASSED **");
        end else begin
            $display("** flash_program_erase_planner_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/fpep_pkg.sv
rtl/fpep_ctrl.sv
rtl/fpep_dp.sv
rtl/flash_program_erase_planner_core.sv
tb/fpep_op_checker.sv
tb/tb_flash_program_erase_planner_core.sv
